[src/cpht_pkg.sv]
// cpht_pkg: shared types, codes and constants of the chained probe hash table
// no dependencies; used by cpht_hash and chained_probe_hash_table
package cpht_pkg;

   localparam int KEY_BITS    = 64;
   localparam int LINK_BITS   = 7;
   localparam int OFFSET_BITS = 20;
   localparam int PROBE_SLOTS = 128;
   localparam int COUNT_BITS  = 11;

   localparam logic [63:0] HASH_MUL = 64'd11400714819323198103;

   localparam logic [1:0] FN_LOOKUP = 2'd0;
   localparam logic [1:0] FN_INSERT = 2'd1;
   localparam logic [1:0] FN_REMOVE = 2'd2;
   localparam logic [1:0] FN_NONE   = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [23:0] RATIO_Q23 [14] = '{
      24'd8455180, 24'd8531592, 24'd8600085, 24'd8663637, 24'd8724152,
      24'd8783359, 24'd8839605, 24'd8895255, 24'd8951156, 24'd9006169,
      24'd9061408, 24'd9115791, 24'd9173052, 24'd9227469
   };

   typedef logic [PROBE_SLOTS-1:0][OFFSET_BITS-1:0] offset_table_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [KEY_BITS-1:0] key;
      logic [63:0]         value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [63:0]           value_out;
      logic [COUNT_BITS-1:0] entry_count;
   } rsp_type;

   // geometric probe offsets, evaluated at elaboration
   function automatic offset_table_type build_offsets(input int table_bits,
                                                      input int probe_count);
      offset_table_type t;
      longint unsigned  p;
      longint unsigned  r;
      t = '0;
      p = 64'd1;
      r = 64'(RATIO_Q23[table_bits - 7]);
      for (int i = 1; i < probe_count - 1; i++) begin
         t[i] = p[OFFSET_BITS-1:0];
         p = (p * r + 64'd8388607) >> 23;
      end
      return t;
   endfunction

endpackage

[src/cpht_ram.sv]
// cpht_ram: generic single write port, single read port memory, registered read
// no dependencies
module cpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cpht_hash.sv]
// cpht_hash: multiplicative home bucket hash, one partial product per step
// one shared 32x32 multiplier; depends on cpht_pkg
module cpht_hash #(
   parameter int TABLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [63:0]           key,
   output logic                  done,
   output logic [TABLE_BITS-1:0] home
);

   logic [2:0]            step_ff, step_in;
   logic [63:0]           key_ff, key_in;
   logic [63:0]           prod_ff, prod_in;
   logic [63:0]           acc_ff, acc_in;
   logic                  done_ff, done_in;
   logic [TABLE_BITS-1:0] home_ff, home_in;
   logic [31:0]           mul_a, mul_b, hi_sum;
   logic [63:0]           mul_p;

   assign mul_a  = (step_ff == 3'd3) ? key_ff[63:32] : key_ff[31:0];
   assign mul_b  = (step_ff == 3'd2) ? cpht_pkg::HASH_MUL[63:32] : cpht_pkg::HASH_MUL[31:0];
   assign mul_p  = mul_a * mul_b;
   assign hi_sum = acc_ff[63:32] + prod_ff[31:0];

   always_comb begin
      step_in = step_ff;
      key_in  = key_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      home_in = home_ff;
      unique case (step_ff)
         3'd0: begin
            if (start) begin
               key_in  = key;
               step_in = 3'd1;
            end
         end
         3'd1: begin
            prod_in = mul_p;
            step_in = 3'd2;
         end
         3'd2: begin
            acc_in  = prod_ff;
            prod_in = mul_p;
            step_in = 3'd3;
         end
         3'd3: begin
            acc_in  = {hi_sum, acc_ff[31:0]};
            prod_in = mul_p;
            step_in = 3'd4;
         end
         3'd4: begin
            home_in = hi_sum[31 -: TABLE_BITS];
            done_in = 1'b1;
            step_in = 3'd0;
         end
         default: begin
            step_in = 3'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      home_ff <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

[src/chained_probe_hash_table.sv]
// chained_probe_hash_table: top level, bucket memory and operation sequencer
// depends on cpht_pkg, cpht_ram and cpht_hash
//
// One lookup, insert or remove at a time. After reset the bucket memory is
// swept to zero with req_stall high. An operation hashes the key, reads the
// home bucket and then reads one bucket per chain link walked, and an insert
// that searches for a free bucket reads one bucket per gap bucket probed; a
// squatter relocation adds a second hash and a second walk. The cost is set by
// the single read port of the bucket memory, one bucket read per step.
module chained_probe_hash_table #(
   parameter int TABLE_BITS  = 10,
   parameter int PROBE_COUNT = 128,
   parameter int VALUE_BITS  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cpht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cpht_pkg::rsp_type rsp_data
);

   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam int CNT_BITS   = TABLE_BITS + 1;
   localparam logic [cpht_pkg::LINK_BITS-1:0] END_PROBE =
      cpht_pkg::LINK_BITS'(PROBE_COUNT - 1);
   localparam logic [7:0] PROBE_LIMIT = 8'(PROBE_COUNT);
   localparam cpht_pkg::offset_table_type OFFSETS =
      cpht_pkg::build_offsets(TABLE_BITS, PROBE_COUNT);

   typedef struct packed {
      logic [63:0]                    key;
      logic [VALUE_BITS-1:0]          val;
      logic [cpht_pkg::LINK_BITS-1:0] nxt;
      logic                           home;
   } bucket_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_HASH, S_HOME_RD, S_HOME_CK,
      S_LK_RD, S_LK_CK,
      S_RM_RD, S_RM_CK, S_RM_CLR_B, S_RM_SUCC_RD, S_RM_SUCC_CK, S_RM_CLR_S,
      S_IN_RD, S_IN_CK,
      S_SQ_HASH, S_SQ_RD, S_SQ_CK, S_SQ_FIX,
      S_FE_RD, S_FE_CK,
      S_PR_RD, S_PR_CK, S_WR_E, S_WR_C, S_WR_HOME,
      S_RESP
   } state_type;

   function automatic logic [TABLE_BITS-1:0] slot(input logic [TABLE_BITS-1:0] hb,
                                                  input logic [cpht_pkg::LINK_BITS-1:0] p);
      slot = hb + OFFSETS[p][TABLE_BITS-1:0];
   endfunction

   state_type                      state_ff, state_in;
   logic [1:0]                     func_ff, func_in;
   logic [63:0]                    key_ff, key_in;
   logic [VALUE_BITS-1:0]          val_ff, val_in;
   logic [TABLE_BITS-1:0]          h_ff, h_in;
   logic [TABLE_BITS-1:0]          hb_ff, hb_in;
   logic [TABLE_BITS-1:0]          b_ff, b_in;
   logic [TABLE_BITS-1:0]          prevb_ff, prevb_in;
   logic [TABLE_BITS-1:0]          clr_ff, clr_in;
   logic [cpht_pkg::LINK_BITS-1:0] cur_ff, cur_in;
   logic [cpht_pkg::LINK_BITS-1:0] y_ff, y_in;
   logic [7:0]                     n_ff, n_in;
   bucket_type                     home_w_ff, home_w_in;
   bucket_type                     cur_w_ff, cur_w_in;
   bucket_type                     prev_w_ff, prev_w_in;
   logic                           has_prev_ff, has_prev_in;
   logic                           squat_ff, squat_in;
   logic [1:0]                     status_ff, status_in;
   logic [63:0]                    vout_ff, vout_in;
   logic [CNT_BITS-1:0]            count_ff, count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   cpht_pkg::rsp_type              rsp_ff, rsp_in;

   logic                           wr_en, rd_en;
   logic [TABLE_BITS-1:0]          wr_addr, rd_addr, cur_slot;
   bucket_type                     wr_data, rd_data;
   logic [cpht_pkg::LINK_BITS-1:0] nx;
   logic                           nx_end;
   logic [7:0]                     n_next;
   logic                           hash_start, hash_done;
   logic [63:0]                    hash_key;
   logic [TABLE_BITS-1:0]          hash_home;
   logic [63:0]                    link_key;
   logic [VALUE_BITS-1:0]          link_val;

   cpht_ram #(
      .WIDTH ($bits(bucket_type)),
      .DEPTH (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cpht_hash #(
      .TABLE_BITS (TABLE_BITS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (hash_key),
      .done  (hash_done),
      .home  (hash_home)
   );

   assign cur_slot = slot(hb_ff, cur_ff);
   assign nx       = rd_data.nxt;
   assign nx_end   = (nx == '0) || (nx >= END_PROBE);
   assign n_next   = n_ff + 8'd1;
   assign rd_en    = (state_ff == S_HOME_RD) || (state_ff == S_LK_RD) ||
                     (state_ff == S_RM_RD) || (state_ff == S_RM_SUCC_RD) ||
                     (state_ff == S_IN_RD) || (state_ff == S_SQ_RD) ||
                     (state_ff == S_FE_RD) || (state_ff == S_PR_RD);
   assign rd_addr  = slot(hb_ff, (state_ff == S_FE_RD) ? y_ff : cur_ff);
   assign hash_key = (state_ff == S_IDLE) ? req_data.key : rd_data.key;
   assign link_key = squat_ff ? home_w_ff.key : key_ff;
   assign link_val = squat_ff ? home_w_ff.val : val_ff;

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      h_in         = h_ff;
      hb_in        = hb_ff;
      b_in         = b_ff;
      prevb_in     = prevb_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      home_w_in    = home_w_ff;
      cur_w_in     = cur_w_ff;
      prev_w_in    = prev_w_ff;
      has_prev_in  = has_prev_ff;
      squat_in     = squat_ff;
      status_in    = status_ff;
      vout_in      = vout_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_slot;
      wr_data      = '0;
      hash_start   = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in     = req_data.func;
               key_in      = req_data.key;
               val_in      = req_data.value_in[VALUE_BITS-1:0];
               vout_in     = '0;
               squat_in    = 1'b0;
               has_prev_in = 1'b0;
               if (req_data.func == cpht_pkg::FN_LOOKUP ||
                   req_data.func == cpht_pkg::FN_INSERT ||
                   req_data.func == cpht_pkg::FN_REMOVE) begin
                  hash_start = 1'b1;
                  state_in   = S_HASH;
               end else begin
                  status_in = cpht_pkg::ST_MISS;
                  state_in  = S_RESP;
               end
            end
         end
         S_HASH: begin
            if (hash_done) begin
               h_in     = hash_home;
               hb_in    = hash_home;
               cur_in   = '0;
               n_in     = '0;
               state_in = S_HOME_RD;
            end
         end
         S_HOME_RD: begin
            state_in = S_HOME_CK;
         end
         S_HOME_CK: begin
            home_w_in = rd_data;
            unique case (func_ff)
               cpht_pkg::FN_LOOKUP: begin
                  if (rd_data.nxt == '0) begin
                     status_in = cpht_pkg::ST_MISS;
                     state_in  = S_RESP;
                  end else if (rd_data.key == key_ff) begin
                     status_in = cpht_pkg::ST_OK;
                     vout_in   = 64'(rd_data.val);
                     state_in  = S_RESP;
                  end else if (!rd_data.home || nx_end) begin
                     status_in = cpht_pkg::ST_MISS;
                     state_in  = S_RESP;
                  end else begin
                     cur_in   = nx;
                     state_in = S_LK_RD;
                  end
               end
               cpht_pkg::FN_REMOVE: begin
                  if (rd_data.nxt == '0 || !rd_data.home) begin
                     status_in = cpht_pkg::ST_MISS;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_RM_CK;
                  end
               end
               default: begin
                  if (rd_data.nxt == '0) begin
                     wr_en     = 1'b1;
                     wr_addr   = h_ff;
                     wr_data   = '{key: key_ff, val: val_ff, nxt: END_PROBE, home: 1'b1};
                     count_in  = count_ff + 1'b1;
                     status_in = cpht_pkg::ST_OK;
                     state_in  = S_RESP;
                  end else if (rd_data.home) begin
                     state_in = S_IN_CK;
                  end else begin
                     hash_start = 1'b1;
                     state_in   = S_SQ_HASH;
                  end
               end
            endcase
         end
         S_LK_RD: begin
            state_in = S_LK_CK;
         end
         S_LK_CK: begin
            n_in = n_next;
            if (rd_data.key == key_ff) begin
               status_in = cpht_pkg::ST_OK;
               vout_in   = 64'(rd_data.val);
               state_in  = S_RESP;
            end else if (nx_end || n_next >= PROBE_LIMIT) begin
               status_in = cpht_pkg::ST_MISS;
               state_in  = S_RESP;
            end else begin
               cur_in   = nx;
               state_in = S_LK_RD;
            end
         end
         S_RM_RD: begin
            state_in = S_RM_CK;
         end
         S_RM_CK: begin
            n_in = n_next;
            if (rd_data.key == key_ff) begin
               vout_in   = 64'(rd_data.val);
               status_in = cpht_pkg::ST_OK;
               count_in  = count_ff - 1'b1;
               if (has_prev_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = prevb_ff;
                  wr_data  = prev_w_ff;
                  wr_data.nxt = nx;
                  state_in = S_RM_CLR_B;
               end else if (!nx_end) begin
                  cur_w_in = rd_data;
                  b_in     = cur_slot;
                  cur_in   = nx;
                  state_in = S_RM_SUCC_RD;
               end else begin
                  state_in = S_RM_CLR_B;
               end
            end else if (nx_end || n_next >= PROBE_LIMIT) begin
               status_in = cpht_pkg::ST_MISS;
               state_in  = S_RESP;
            end else begin
               prevb_in    = cur_slot;
               prev_w_in   = rd_data;
               has_prev_in = 1'b1;
               cur_in      = nx;
               state_in    = S_RM_RD;
            end
         end
         S_RM_CLR_B: begin
            wr_en    = 1'b1;
            state_in = S_RESP;
         end
         S_RM_SUCC_RD: begin
            state_in = S_RM_SUCC_CK;
         end
         S_RM_SUCC_CK: begin
            wr_en    = 1'b1;
            wr_addr  = b_ff;
            wr_data  = rd_data;
            wr_data.home = cur_w_ff.home;
            state_in = S_RM_CLR_S;
         end
         S_RM_CLR_S: begin
            wr_en    = 1'b1;
            state_in = S_RESP;
         end
         S_IN_RD: begin
            state_in = S_IN_CK;
         end
         S_IN_CK: begin
            n_in = n_next;
            if (rd_data.key == key_ff) begin
               wr_en     = 1'b1;
               wr_data   = rd_data;
               wr_data.val = val_ff;
               status_in = cpht_pkg::ST_OK;
               state_in  = S_RESP;
            end else if (nx_end || n_next >= PROBE_LIMIT) begin
               y_in     = 7'd1;
               state_in = S_FE_RD;
            end else begin
               cur_in   = nx;
               state_in = S_IN_RD;
            end
         end
         S_SQ_HASH: begin
            if (hash_done) begin
               hb_in    = hash_home;
               cur_in   = '0;
               n_in     = '0;
               squat_in = 1'b1;
               state_in = S_SQ_RD;
            end
         end
         S_SQ_RD: begin
            state_in = S_SQ_CK;
         end
         S_SQ_CK: begin
            n_in = n_next;
            if (nx_end) begin
               status_in = cpht_pkg::ST_FULL;
               state_in  = S_RESP;
            end else if (slot(hb_ff, nx) == h_ff) begin
               cur_w_in = rd_data;
               y_in     = 7'd1;
               state_in = S_FE_RD;
            end else if (n_next >= PROBE_LIMIT) begin
               status_in = cpht_pkg::ST_FULL;
               state_in  = S_RESP;
            end else begin
               cur_in   = nx;
               state_in = S_SQ_RD;
            end
         end
         S_SQ_FIX: begin
            wr_en    = 1'b1;
            wr_data  = cur_w_ff;
            wr_data.nxt = home_w_ff.nxt;
            cur_in   = '0;
            n_in     = '0;
            state_in = S_PR_RD;
         end
         S_FE_RD: begin
            state_in = S_FE_CK;
         end
         S_FE_CK: begin
            if (rd_data.nxt == '0) begin
               if (squat_ff) begin
                  state_in = S_SQ_FIX;
               end else begin
                  cur_in   = '0;
                  n_in     = '0;
                  state_in = S_PR_RD;
               end
            end else if (y_ff + 1'b1 < END_PROBE) begin
               y_in     = y_ff + 1'b1;
               state_in = S_FE_RD;
            end else begin
               status_in = cpht_pkg::ST_FULL;
               state_in  = S_RESP;
            end
         end
         S_PR_RD: begin
            state_in = S_PR_CK;
         end
         S_PR_CK: begin
            n_in = n_next;
            if (nx == '0 || nx >= y_ff || n_next >= PROBE_LIMIT) begin
               cur_w_in = rd_data;
               state_in = S_WR_E;
            end else begin
               cur_in   = nx;
               state_in = S_PR_RD;
            end
         end
         S_WR_E: begin
            wr_en    = 1'b1;
            wr_addr  = slot(hb_ff, y_ff);
            wr_data  = '{key: link_key, val: link_val, nxt: cur_w_ff.nxt, home: 1'b0};
            state_in = S_WR_C;
         end
         S_WR_C: begin
            wr_en    = 1'b1;
            wr_data  = cur_w_ff;
            wr_data.nxt = y_ff;
            if (squat_ff) begin
               state_in = S_WR_HOME;
            end else begin
               count_in  = count_ff + 1'b1;
               status_in = cpht_pkg::ST_OK;
               state_in  = S_RESP;
            end
         end
         S_WR_HOME: begin
            wr_en     = 1'b1;
            wr_addr   = h_ff;
            wr_data   = '{key: key_ff, val: val_ff, nxt: END_PROBE, home: 1'b1};
            count_in  = count_ff + 1'b1;
            status_in = cpht_pkg::ST_OK;
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = status_ff;
               rsp_in.value_out   = vout_ff;
               rsp_in.entry_count = cpht_pkg::COUNT_BITS'(count_ff);
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         squat_ff     <= 1'b0;
         has_prev_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         squat_ff     <= squat_in;
         has_prev_ff  <= has_prev_in;
      end
      func_ff   <= func_in;
      key_ff    <= key_in;
      val_ff    <= val_in;
      h_ff      <= h_in;
      hb_ff     <= hb_in;
      b_ff      <= b_in;
      prevb_ff  <= prevb_in;
      cur_ff    <= cur_in;
      y_ff      <= y_in;
      n_ff      <= n_in;
      home_w_ff <= home_w_in;
      cur_w_ff  <= cur_w_in;
      prev_w_ff <= prev_w_in;
      status_ff <= status_in;
      vout_ff   <= vout_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= TABLE_SIZE)
      else $error("entry count above table size");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("response raised outside response state");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !wr_en)
      else $error("bucket write while idle");

   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FE_RD) |-> (y_ff != '0 && y_ff < END_PROBE))
      else $error("free bucket search out of probe range");

   a_hash_wait: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == S_HASH || state_ff == S_SQ_HASH))
      else $error("hash result with no one waiting");

endmodule

[tb/sv/tb_chained_probe_hash_table.sv]
// tb_chained_probe_hash_table: self-checking bench for the chained probe hash table
// depends on cpht_pkg and chained_probe_hash_table; a behavioral table predicts
// every response, which is compared field by field in transfer order
`timescale 1ns / 1ps

module tb_chained_probe_hash_table;

   localparam int TBITS = 10;
   localparam int TSIZE = 1 << TBITS;
   localparam int NPROBE = 128;
   localparam int ENDP = NPROBE - 1;
   localparam int CYCLE_LIMIT = 8000000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cpht_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cpht_pkg::rsp_type rsp_data;

   chained_probe_hash_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // table image
   logic [63:0] tab_key [TSIZE];
   logic [63:0] tab_val [TSIZE];
   int          tab_link [TSIZE];
   bit          tab_home [TSIZE];
   int          live_count;
   int          offs [NPROBE];

   cpht_pkg::req_type pending_reqs [$];
   cpht_pkg::rsp_type expected_rsps [$];
   logic [63:0]       used_keys [$];
   int                fail_count = 0;
   int                rsp_count = 0;
   int                cycle_count = 0;
   int                hold_cycles = 0;
   int                st_seen [3];
   logic              req_fired = 1'b0;

   function automatic int home_of(logic [63:0] k);
      logic [63:0] m;
      m = k * cpht_pkg::HASH_MUL;
      return int'(m[63 -: TBITS]);
   endfunction

   function automatic int bucket(int h, int p);
      return (h + offs[p]) & (TSIZE - 1);
   endfunction

   function automatic void clear_bucket(int i);
      tab_key[i] = '0; tab_val[i] = '0; tab_link[i] = 0; tab_home[i] = 0;
   endfunction

   function automatic int first_free(int h);
      for (int y = 1; y < ENDP; y++)
         if (tab_link[bucket(h, y)] == 0) return y;
      return -1;
   endfunction

   function automatic int chain_pred(int h, int y);
      int cur, nx;
      cur = 0;
      for (int n = 0; n < NPROBE; n++) begin
         nx = tab_link[bucket(h, cur)];
         if (nx == 0 || nx >= y) break;
         cur = nx;
      end
      return cur;
   endfunction

   function automatic void link_in(int h, int y, logic [63:0] k, logic [63:0] v);
      int c, e;
      c = bucket(h, chain_pred(h, y));
      e = bucket(h, y);
      tab_key[e] = k; tab_val[e] = v; tab_link[e] = tab_link[c]; tab_home[e] = 0;
      tab_link[c] = y;
   endfunction

   function automatic logic [1:0] table_insert(logic [63:0] k, logic [63:0] v);
      int h, cur, nx, b, y, h2;
      logic [63:0] k2;
      bit found;
      h = home_of(k);
      cur = 0;
      found = 0;
      if (tab_link[h] == 0) begin
         tab_key[h] = k; tab_val[h] = v; tab_link[h] = ENDP; tab_home[h] = 1;
         live_count++;
         return cpht_pkg::ST_OK;
      end
      if (tab_home[h]) begin
         for (int n = 0; n < NPROBE; n++) begin
            b = bucket(h, cur);
            if (tab_key[b] == k) begin
               tab_val[b] = v;
               return cpht_pkg::ST_OK;
            end
            nx = tab_link[b];
            if (nx == 0 || nx >= ENDP) break;
            cur = nx;
         end
         y = first_free(h);
         if (y < 0) return cpht_pkg::ST_FULL;
         link_in(h, y, k, v);
         live_count++;
         return cpht_pkg::ST_OK;
      end
      k2 = tab_key[h];
      h2 = home_of(k2);
      for (int n = 0; n < NPROBE; n++) begin
         nx = tab_link[bucket(h2, cur)];
         if (nx == 0 || nx >= ENDP) break;
         if (bucket(h2, nx) == h) begin
            found = 1;
            break;
         end
         cur = nx;
      end
      if (!found) return cpht_pkg::ST_FULL;
      y = first_free(h2);
      if (y < 0) return cpht_pkg::ST_FULL;
      tab_link[bucket(h2, cur)] = tab_link[h];
      link_in(h2, y, k2, tab_val[h]);
      tab_key[h] = k; tab_val[h] = v; tab_link[h] = ENDP; tab_home[h] = 1;
      live_count++;
      return cpht_pkg::ST_OK;
   endfunction

   function automatic logic [1:0] table_lookup(logic [63:0] k, output logic [63:0] v);
      int h, cur, b;
      h = home_of(k);
      v = '0;
      if (tab_link[h] == 0) return cpht_pkg::ST_MISS;
      if (tab_key[h] == k) begin
         v = tab_val[h];
         return cpht_pkg::ST_OK;
      end
      if (!tab_home[h]) return cpht_pkg::ST_MISS;
      cur = tab_link[h];
      for (int n = 0; n < NPROBE && cur != 0 && cur < ENDP; n++) begin
         b = bucket(h, cur);
         if (tab_key[b] == k) begin
            v = tab_val[b];
            return cpht_pkg::ST_OK;
         end
         cur = tab_link[b];
      end
      return cpht_pkg::ST_MISS;
   endfunction

   function automatic logic [1:0] table_remove(logic [63:0] k, output logic [63:0] v);
      int h, cur, nx, b, prevb, s;
      bit has_prev;
      h = home_of(k);
      v = '0;
      cur = 0;
      prevb = 0;
      has_prev = 0;
      if (tab_link[h] == 0 || !tab_home[h]) return cpht_pkg::ST_MISS;
      for (int n = 0; n < NPROBE; n++) begin
         b = bucket(h, cur);
         nx = tab_link[b];
         if (tab_key[b] == k) begin
            v = tab_val[b];
            if (has_prev) begin
               tab_link[prevb] = nx;
               clear_bucket(b);
            end else if (nx != 0 && nx < ENDP) begin
               s = bucket(h, nx);
               tab_key[b] = tab_key[s]; tab_val[b] = tab_val[s]; tab_link[b] = tab_link[s];
               clear_bucket(s);
            end else begin
               clear_bucket(b);
            end
            live_count--;
            return cpht_pkg::ST_OK;
         end
         if (nx == 0 || nx >= ENDP) break;
         prevb = b;
         has_prev = 1;
         cur = nx;
      end
      return cpht_pkg::ST_MISS;
   endfunction

   function automatic cpht_pkg::rsp_type predict_op(cpht_pkg::req_type r);
      cpht_pkg::rsp_type o;
      logic [63:0] v;
      v = '0;
      case (r.func)
         cpht_pkg::FN_LOOKUP: o.status = table_lookup(r.key, v);
         cpht_pkg::FN_INSERT: o.status = table_insert(r.key, r.value_in);
         cpht_pkg::FN_REMOVE: o.status = table_remove(r.key, v);
         default: o.status = cpht_pkg::ST_MISS;
      endcase
      o.value_out = v;
      o.entry_count = live_count[cpht_pkg::COUNT_BITS-1:0];
      return o;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // keys in a few crowded home groups to build long chains and squatters
   function automatic logic [63:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (used_keys.size() > 0 && sel < 5)
         return used_keys[$urandom_range(0, used_keys.size() - 1)];
      if (sel < 8)
         return {48'h0, 6'($urandom_range(0, 63)), 10'($urandom())};
      return rand64();
   endfunction

   task automatic add_req(logic [1:0] f, logic [63:0] k, logic [63:0] v);
      cpht_pkg::req_type r;
      r.func = f; r.key = k; r.value_in = v;
      pending_reqs.push_back(r);
      if (f == cpht_pkg::FN_INSERT) used_keys.push_back(k);
   endtask

   // driver
   int req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_fired) begin
            if (pending_reqs.size() > 0 && req_gap == 0) begin
               req_data <= pending_reqs.pop_front();
               req_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (req_gap > 0) req_gap--;
            else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end
         end
      end
   end

   // accepted transfer sampled at the rising edge
   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(predict_op(req_data));
      end
   end

   // monitor
   always @(posedge clock) begin
      cpht_pkg::rsp_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response status %0d", rsp_data.status);
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            st_seen[e.status]++;
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.value_out !== e.value_out) begin
               $error("value_out exp %h got %h", e.value_out, rsp_data.value_out);
               fail_count++;
            end
            if (rsp_data.entry_count !== e.entry_count) begin
               $error("entry_count exp %0d got %0d", e.entry_count, rsp_data.entry_count);
               fail_count++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // receiver stalls
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid && $urandom_range(0, 3) == 0) rsp_gap = $urandom_range(0, 18);
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [63:0] k;
      int f;
      offs[0] = 0;
      offs[ENDP] = 0;
      begin
         longint unsigned p, r;
         p = 1;
         r = 64'(cpht_pkg::RATIO_Q23[TBITS - 7]);
         for (int i = 1; i < ENDP; i++) begin
            offs[i] = int'(p & 64'hFFFFF);
            p = (p * r + 64'd8388607) >> 23;
         end
      end
      for (int i = 0; i < TSIZE; i++) clear_bucket(i);
      live_count = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty-bucket key 0, extremes, every func, overwrite, chain ops
      add_req(cpht_pkg::FN_LOOKUP, 64'h0, 64'h0);
      add_req(cpht_pkg::FN_REMOVE, 64'h0, 64'h0);
      add_req(cpht_pkg::FN_INSERT, 64'h0, '1);
      add_req(cpht_pkg::FN_LOOKUP, 64'h0, 64'h0);
      add_req(cpht_pkg::FN_INSERT, '1, '1);
      add_req(cpht_pkg::FN_INSERT, '1, 64'h5555_AAAA_5555_AAAA);
      add_req(cpht_pkg::FN_LOOKUP, '1, 64'h0);
      add_req(cpht_pkg::FN_NONE, '1, '1);
      for (int i = 1; i <= 6; i++) add_req(cpht_pkg::FN_INSERT, 64'(i * TSIZE), 64'(i));
      add_req(cpht_pkg::FN_REMOVE, 64'(TSIZE), 64'h0);
      add_req(cpht_pkg::FN_LOOKUP, 64'(3 * TSIZE), 64'h0);
      add_req(cpht_pkg::FN_REMOVE, 64'(4 * TSIZE), 64'h0);
      add_req(cpht_pkg::FN_REMOVE, 64'h0, 64'h0);
      add_req(cpht_pkg::FN_REMOVE, '1, 64'h0);
      add_req(cpht_pkg::FN_LOOKUP, 64'h8000_0000_0000_0000, 64'h0);
      wait_drained();

      // long receiver hold while the sender keeps offering
      hold_cycles = 600;
      for (int i = 0; i < 40; i++) add_req(cpht_pkg::FN_INSERT, pick_key(), rand64());
      wait_drained();

      for (int i = 0; i < 1450; i++) begin
         k = pick_key();
         f = $urandom_range(0, 19);
         if (f < 9) add_req(cpht_pkg::FN_INSERT, k, rand64());
         else if (f < 14) add_req(cpht_pkg::FN_LOOKUP, k, rand64());
         else if (f < 19) add_req(cpht_pkg::FN_REMOVE, k, rand64());
         else add_req(cpht_pkg::FN_NONE, k, rand64());
         if (i % 300 == 299) wait_drained();
      end
      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d responses: ok %0d, miss %0d, full %0d, final count %0d",
               rsp_count, st_seen[cpht_pkg::ST_OK], st_seen[cpht_pkg::ST_MISS],
               st_seen[cpht_pkg::ST_FULL], live_count);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
